FILE: rtl/core/pfx_pkg.sv
// shared types and constants for the postfix expression evaluator
// no dependencies; used by the evaluator core, the divider and the checker
`default_nettype none

package pfx_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 16;

  // character codes
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_DIVZERO  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/core/pfx_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on pfx_pkg for the data width
`default_nettype none

module pfx_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [pfx_pkg::DATA_W-1:0]  num,
  input  wire logic [pfx_pkg::DATA_W-1:0]  den,
  output logic                             done,
  output logic [pfx_pkg::DATA_W-1:0]       quo
);

  localparam int W  = pfx_pkg::DATA_W;
  localparam int SW = $clog2(W);

  logic          busy_r;
  logic [SW-1:0] step_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  dvd_r;
  logic [W-1:0]  dm_r;
  logic          neg_r;
  logic          done_r;
  logic [W-1:0]  quo_r;

  logic [W:0]    trial;
  logic          qbit;
  logic [W-1:0]  q_next;

  // one restoring step
  always_comb begin
    trial  = {rem_r, dvd_r[W-1]};
    qbit   = (trial >= {1'b0, dm_r});
    q_next = {dvd_r[W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        dvd_r  <= num[W-1] ? (W'(0) - num) : num;
        dm_r   <= den[W-1] ? (W'(0) - den) : den;
        neg_r  <= num[W-1] ^ den[W-1];
      end else if (busy_r) begin
        rem_r  <= qbit ? W'(trial - {1'b0, dm_r}) : trial[W-1:0];
        dvd_r  <= q_next;
        step_r <= step_r + SW'(1);
        if (step_r == SW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quo_r  <= neg_r ? (W'(0) - q_next) : q_next;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

FILE: rtl/core/postfix_expression_evaluator.sv
// postfix expression evaluator top level: stack memory and sequencer
// depends on pfx_pkg and pfx_div
//
//   channel | ports                         | payload
//   --------+-------------------------------+------------------------------
//   input   | in_valid, in_ready, in_data   | pfx_pkg::in_t  (symbol, last)
//   result  | out_valid, out_ready, out_data| pfx_pkg::out_t (value, status)
//
// one character at a time: an operand is pushed, a parenthesis pops two, + - * pop two
// and push the result, and / also waits for the divider (it retires one bit a cycle)
// the single-port stack memory allows one read per cycle, so pops are serial
// the final character adds a read of the result in S_FIN_RD before S_FIN hands it over
// reset clears the stack count, the error code and the result valid
// a held result stalls only the hand-over in S_FIN; input is taken until then
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pfx_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pfx_pkg::out_t      out_data
);

  localparam int W  = pfx_pkg::DATA_W;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_POP_A, S_POP_B, S_DIV, S_PUSH, S_FIN_RD, S_FIN
  } state_t;

  // stack memory
  logic [W-1:0] stack_mem [STACK_DEPTH];
  logic [W-1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [W-1:0]  mem_wd;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  state_t        state_r, state_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  pfx_pkg::out_t out_data_r, out_data_nxt;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [W-1:0]  b_val;
  logic          in_is_op;
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_quo;

  pfx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (b_val),
    .den   (a_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign b_val    = (cnt_r == '0) ? '1 : rd_data_r;
  assign in_is_op = (in_data.symbol == pfx_pkg::CH_LPAR) || (in_data.symbol == pfx_pkg::CH_RPAR)
                 || (in_data.symbol == pfx_pkg::CH_MUL)  || (in_data.symbol == pfx_pkg::CH_ADD)
                 || (in_data.symbol == pfx_pkg::CH_SUB)  || (in_data.symbol == pfx_pkg::CH_DIV);
  assign in_ready = (state_r == S_IDLE);

  // first error of an expression is kept
  function automatic logic [1:0] note_err(input logic [1:0] cur, input logic [1:0] code);
    note_err = (cur == pfx_pkg::ST_OK) ? code : cur;
  endfunction

  // sequencer next-state and memory control
  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    a_nxt         = a_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_wa        = cnt_r[AW-1:0];
    mem_wd        = res_r;
    rd_en         = 1'b0;
    rd_addr       = cnt_m1[AW-1:0];
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt  = in_data.symbol;
          last_nxt = in_data.last;
          rd_en    = 1'b1;
          if (in_is_op) begin
            state_nxt = S_POP_A;
          end else begin
            res_nxt   = {{(W-8){1'b0}}, in_data.symbol} - {{(W-8){1'b0}}, pfx_pkg::CH_ZERO};
            state_nxt = S_PUSH;
          end
        end
      end
      S_POP_A: begin
        if (cnt_r == '0) begin
          a_nxt   = '1;
          err_nxt = note_err(err_nxt, pfx_pkg::ST_EMPTY);
        end else begin
          a_nxt   = rd_data_r;
          cnt_nxt = cnt_m1;
        end
        rd_en     = 1'b1;
        rd_addr   = cnt_m2[AW-1:0];
        state_nxt = S_POP_B;
      end
      S_POP_B: begin
        if (cnt_r == '0) begin
          err_nxt = note_err(err_nxt, pfx_pkg::ST_EMPTY);
        end else begin
          cnt_nxt = cnt_m1;
        end
        priority case (sym_r)
          pfx_pkg::CH_ADD: begin
            res_nxt   = b_val + a_r;
            state_nxt = S_PUSH;
          end
          pfx_pkg::CH_SUB: begin
            res_nxt   = b_val - a_r;
            state_nxt = S_PUSH;
          end
          pfx_pkg::CH_MUL: begin
            res_nxt   = b_val * a_r;
            state_nxt = S_PUSH;
          end
          pfx_pkg::CH_DIV: begin
            if (a_r == '0) begin
              err_nxt   = note_err(err_nxt, pfx_pkg::ST_DIVZERO);
              res_nxt   = '0;
              state_nxt = S_PUSH;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          default: begin
            // parenthesis: two pops, nothing pushed
            state_nxt = last_r ? S_FIN_RD : S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = div_quo;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (cnt_r < CW'(STACK_DEPTH)) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          err_nxt = note_err(err_nxt, pfx_pkg::ST_OVERFLOW);
        end
        state_nxt = last_r ? S_FIN_RD : S_IDLE;
      end
      S_FIN_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for the result register to free up
        if (!out_valid_r || out_ready) begin
          out_data_nxt.value  = (cnt_r == '0) ? '1 : rd_data_r;
          out_data_nxt.status = note_err(err_r,
                                  (cnt_r == '0) ? pfx_pkg::ST_EMPTY : pfx_pkg::ST_OK);
          out_valid_nxt       = 1'b1;
          cnt_nxt             = '0;
          err_nxt             = pfx_pkg::ST_OK;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= pfx_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r      <= sym_nxt;
    last_r     <= last_nxt;
    a_r        <= a_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/pfx_chk.sv
// port-level checker for the postfix expression evaluator, with its bind
// depends on pfx_pkg and the top level postfix_expression_evaluator
`default_nettype none

module pfx_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire pfx_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire pfx_pkg::out_t out_data
);

  logic [1:0] pend_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // final characters taken in minus results delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'((in_xfer && in_data.last) ? 1 : 0) - 2'(out_xfer ? 1 : 0);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one character at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // every result follows a final character
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a final character");

  // at most one expression in flight and one result waiting
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many outstanding results");

endmodule

bind postfix_expression_evaluator pfx_chk u_pfx_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for postfix_expression_evaluator: directed table, then random expressions
// keeps its own stack model of the evaluator; depends on pfx_pkg and the evaluator rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1550;
  localparam int DRAIN_EVERY = 400;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 60;

  localparam logic [0:5][7:0] ALL_OPS = {pfx_pkg::CH_LPAR, pfx_pkg::CH_RPAR,
                                         pfx_pkg::CH_MUL, pfx_pkg::CH_ADD,
                                         pfx_pkg::CH_SUB, pfx_pkg::CH_DIV};
  // 128^4 * 8 wraps to the most negative value, then 0 - 1 gives the divisor
  localparam logic [0:12][7:0] WRAP_SEQ = {8'd176, 8'd176, pfx_pkg::CH_MUL,
                                           8'd176, pfx_pkg::CH_MUL,
                                           8'd176, pfx_pkg::CH_MUL,
                                           pfx_pkg::CH_ZERO + 8'd8, pfx_pkg::CH_MUL,
                                           pfx_pkg::CH_ZERO, pfx_pkg::CH_ZERO + 8'd1,
                                           pfx_pkg::CH_SUB, pfx_pkg::CH_DIV};

  typedef struct packed {
    logic [7:0]         symbol;
    logic               last;
    logic               typed;
    logic signed [31:0] value;
    logic [1:0]         status;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  pfx_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  pfx_pkg::out_t out_data;

  // expected results of finished expressions, oldest first
  pfx_pkg::out_t pending_results[$];
  int   error_total = 0;
  int   items_sent = 0;
  int   burst_left = 0;

  // model of the value stack and the first error of the running expression
  logic [31:0] stack_mem [pfx_pkg::STACK_DEPTH];
  int          stack_fill = 0;
  logic [1:0]  expr_err = pfx_pkg::ST_OK;

  // directed expressions; typed rows carry their obvious result
  dir_row_t directed_rows [26] = '{
    // lone operand
    '{pfx_pkg::CH_ZERO + 8'd5, 1'b1, 1'b1, 32'sd5, pfx_pkg::ST_OK},
    // operator on empty stack: both pops give -1
    '{pfx_pkg::CH_ADD, 1'b1, 1'b1, -32'sd2, pfx_pkg::ST_EMPTY},
    // parenthesis on empty stack, final pop empty too
    '{pfx_pkg::CH_LPAR, 1'b1, 1'b1, -32'sd1, pfx_pkg::ST_EMPTY},
    // division by zero pushes 0
    '{pfx_pkg::CH_ZERO + 8'd9, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_DIV, 1'b1, 1'b1, 32'sd0, pfx_pkg::ST_DIVZERO},
    // operand order: b - a
    '{pfx_pkg::CH_ZERO + 8'd8, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_SUB, 1'b1, 1'b1, 32'sd5, pfx_pkg::ST_OK},
    // operand order: b / a
    '{pfx_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_DIV, 1'b1, 1'b1, 32'sd3, pfx_pkg::ST_OK},
    // multiply
    '{pfx_pkg::CH_ZERO + 8'd6, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_MUL, 1'b1, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    // closing parenthesis drops the top two
    '{pfx_pkg::CH_ZERO + 8'd4, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd6, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_RPAR, 1'b1, 1'b1, 32'sd4, pfx_pkg::ST_OK},
    // symbol extremes and a non-digit operand
    '{8'h00, 1'b1, 1'b1, -32'sd48, pfx_pkg::ST_OK},
    '{8'hFF, 1'b1, 1'b1, 32'sd207, pfx_pkg::ST_OK},
    '{8'h20, 1'b1, 1'b1, -32'sd16, pfx_pkg::ST_OK},
    // empty pop first, then zero divide: the first error stays
    '{pfx_pkg::CH_LPAR, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_DIV, 1'b1, 1'b1, 32'sd0, pfx_pkg::ST_EMPTY}
  };

  postfix_expression_evaluator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void note_fault(input logic [1:0] code);
    if (expr_err == pfx_pkg::ST_OK) expr_err = code;
  endfunction

  function automatic void push_word(input logic [31:0] word);
    if (stack_fill >= pfx_pkg::STACK_DEPTH) begin
      note_fault(pfx_pkg::ST_OVERFLOW);
    end else begin
      stack_mem[stack_fill] = word;
      stack_fill++;
    end
  endfunction

  function automatic logic [31:0] pop_word();
    if (stack_fill == 0) begin
      note_fault(pfx_pkg::ST_EMPTY);
      return 32'hFFFF_FFFF;
    end
    stack_fill--;
    return stack_mem[stack_fill];
  endfunction

  // signed division on magnitudes, truncating toward zero
  function automatic logic [31:0] div_toward_zero(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] num_mag, den_mag, quot;
    num_mag = num[31] ? 32'd0 - num : num;
    den_mag = den[31] ? 32'd0 - den : den;
    quot = num_mag / den_mag;
    return (num[31] ^ den[31]) ? 32'd0 - quot : quot;
  endfunction

  // apply one character to the stack model; returns 1 when it closes an expression
  function automatic bit rpn_apply(input pfx_pkg::in_t item, output pfx_pkg::out_t res);
    logic [31:0] rhs, lhs, acc;
    res = '0;
    case (item.symbol)
      pfx_pkg::CH_LPAR, pfx_pkg::CH_RPAR: begin
        rhs = pop_word();
        lhs = pop_word();
      end
      pfx_pkg::CH_ADD, pfx_pkg::CH_SUB, pfx_pkg::CH_MUL, pfx_pkg::CH_DIV: begin
        rhs = pop_word();
        lhs = pop_word();
        case (item.symbol)
          pfx_pkg::CH_ADD: acc = lhs + rhs;
          pfx_pkg::CH_SUB: acc = lhs - rhs;
          pfx_pkg::CH_MUL: acc = lhs * rhs;
          default: begin
            if (rhs == 32'd0) begin
              note_fault(pfx_pkg::ST_DIVZERO);
              acc = 32'd0;
            end else begin
              acc = div_toward_zero(lhs, rhs);
            end
          end
        endcase
        push_word(acc);
      end
      default: push_word({24'd0, item.symbol} - 32'd48);
    endcase
    if (!item.last) return 1'b0;
    res.value  = pop_word();
    res.status = expr_err;
    stack_fill = 0;
    expr_err   = pfx_pkg::ST_OK;
    return 1'b1;
  endfunction

  // operand character: mostly a digit, sometimes any non-operator byte
  function automatic logic [7:0] pick_operand();
    logic [7:0] sym;
    if ($urandom_range(0, 4) != 0) return pfx_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    do begin
      sym = 8'($urandom_range(0, 255));
    end while (sym == pfx_pkg::CH_LPAR || sym == pfx_pkg::CH_RPAR ||
               sym == pfx_pkg::CH_MUL || sym == pfx_pkg::CH_ADD ||
               sym == pfx_pkg::CH_SUB || sym == pfx_pkg::CH_DIV);
    return sym;
  endfunction

  // one input transfer, with a random gap whenever a burst runs out
  task automatic send_symbol(input logic [7:0] sym, input bit fin, input bit typed,
                             input pfx_pkg::out_t typed_res);
    pfx_pkg::in_t  item;
    pfx_pkg::out_t res;
    int   gap;
    item.symbol = sym;
    item.last   = fin;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (rpn_apply(item, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  // hold the input side idle until every pending result has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin : check_results
    pfx_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: value %0d status %0d",
               out_data.value, out_data.status);
        error_total++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value !== want.value) begin
          $error("value mismatch: expected %0d actual %0d", want.value, out_data.value);
          error_total++;
        end
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, out_data.status);
          error_total++;
        end
      end
    end
  end

  // receiver stall pattern, switching to a random mode at random intervals
  always @(negedge clk) begin : rx_stall
    static rx_mode_t rx_mode = RX_OPEN;
    static int rx_left = 0;
    static int rx_phase = 0;
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 128);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_phase % 7) < 3;
    endcase
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    static int idle_cycles = 0;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int   kind, n_ops, n_vals, ops_left, vals_left, depth, next_drain;
    logic [7:0] sym;
    pfx_pkg::out_t typed_res;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      typed_res.value  = directed_rows[i].value;
      typed_res.status = directed_rows[i].status;
      send_symbol(directed_rows[i].symbol, directed_rows[i].last, directed_rows[i].typed,
                  typed_res);
    end
    drain_results();

    // random expressions
    next_drain = DRAIN_EVERY;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        // well-formed arithmetic with random operands
        n_ops = $urandom_range(0, 7);
        vals_left = n_ops + 1;
        ops_left = n_ops;
        depth = 0;
        while (vals_left + ops_left > 0) begin
          if (depth >= 2 && ops_left > 0 && (vals_left == 0 || $urandom_range(0, 1))) begin
            sym = ALL_OPS[$urandom_range(2, 5)];
            ops_left--;
            depth--;
          end else begin
            sym = pick_operand();
            vals_left--;
            depth++;
          end
          send_symbol(sym, vals_left + ops_left == 0, 1'b0, '0);
        end
      end else if (kind < 83) begin
        // noise: any byte, operators and parentheses weighted up
        n_vals = $urandom_range(1, 12);
        for (int k = 0; k < n_vals; k++) begin
          sym = $urandom_range(0, 1) ? ALL_OPS[$urandom_range(0, 5)] : 8'($urandom_range(0, 255));
          send_symbol(sym, k == n_vals - 1, 1'b0, '0);
        end
      end else if (kind < 95) begin
        // fill past the stack depth, then a few operators
        n_vals = $urandom_range(pfx_pkg::STACK_DEPTH + 1, pfx_pkg::STACK_DEPTH + 4);
        n_ops = $urandom_range(0, 4);
        for (int k = 0; k < n_vals + n_ops; k++) begin
          sym = (k < n_vals) ? pick_operand() : ALL_OPS[$urandom_range(0, 5)];
          send_symbol(sym, k == n_vals + n_ops - 1, 1'b0, '0);
        end
      end else begin
        // most negative value divided by -1
        for (int k = 0; k < 13; k++) send_symbol(WRAP_SEQ[k], k == 12, 1'b0, '0);
      end
      if (items_sent >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
    end

    // let the last results out, then a short tail for stray transfers
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_total == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
